// File: hdl/i2c_transaction_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// I2C transaction sequencer assertion macros
// Shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef I2C_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH
`define I2C_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define I2CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// I2C transaction sequencer package
// Shared types, codes and constants of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cts_pkg;

  localparam int unsigned MaxLengthDef = 255;
  localparam int unsigned TimeoutW     = 20;
  localparam logic [TimeoutW-1:0] TimeoutResetVal = 20'd1000000;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_WBYTE   = 2'd1,
    OP_STATUS  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  localparam logic [2:0] KIND_PROBE     = 3'd0;
  localparam logic [2:0] KIND_WRITE     = 3'd1;
  localparam logic [2:0] KIND_READ      = 3'd2;
  localparam logic [2:0] KIND_REG_WRITE = 3'd3;
  localparam logic [2:0] KIND_REG_READ  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_ARB     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef enum logic [16:0] {
    PH_IDLE         = 17'h00001,
    PH_PREP_CHECK   = 17'h00002,
    PH_PREP_CLEAR   = 17'h00004,
    PH_PREP_READY   = 17'h00008,
    PH_PREP_NOTBUSY = 17'h00010,
    PH_START_PRE    = 17'h00020,
    PH_AWAIT_BYTE   = 17'h00040,
    PH_FAIL_CHECK   = 17'h00080,
    PH_RUN_START    = 17'h00100,
    PH_RUN_ADDR     = 17'h00200,
    PH_RUN_REG      = 17'h00400,
    PH_RUN_RESTART  = 17'h00800,
    PH_RUN_ADDR2    = 17'h01000,
    PH_RUN_WDATA    = 17'h02000,
    PH_RUN_RDATA    = 17'h04000,
    PH_RUN_STOP     = 17'h08000,
    PH_RUN_FAILSTOP = 17'h10000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [2:0]          held_kind;
    logic [6:0]          held_device;
    logic [7:0]          held_register;
    logic                saw_not_ready;
    logic [TimeoutW-1:0] wait_count;
    logic [1:0]          pending_failure;
  } seq_state_t;

  typedef struct packed {
    op_e        op;
    logic [2:0] kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       core_ready;
    logic       core_busy;
    logic       core_arb_lost;
    logic       core_nack;
    logic [7:0] core_rdata;
  } item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cmd_data;
    logic       clear_arb_lost;
    logic       want_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

// File: hdl/i2cts_step.sv
// ----------------------------------------------------------------------------
// I2C transaction sequencer step logic
// Next state and result of the sequencer for one registered input item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cts_step import i2cts_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MaxLengthDef,
  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1)
) (
  input  item_t               item_i,
  input  seq_state_t          state_i,
  input  logic [LenW-1:0]     bytes_left_i,
  input  logic [TimeoutW-1:0] timeout_i,
  output seq_state_t          state_o,
  output logic [LenW-1:0]     bytes_left_o,
  output result_t             res_o,
  output logic                res_valid_o
);

  localparam int unsigned CmpW = (LenW > 8) ? LenW : 8;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_LENGTH);

  seq_state_t          st;
  logic [LenW-1:0]     bl;
  logic [LenW-1:0]     bl_dec;
  logic [CmpW-1:0]     len_ext;
  logic [CmpW-1:0]     len_sat;
  result_t             r;
  logic                do_iss;
  cmd_e                iss_cmd;
  logic [7:0]          iss_data;
  phase_e              iss_ph;
  logic                do_fin;
  logic [1:0]          fin_st;
  logic                do_ask;
  logic                adv_en;
  phase_e              adv_from;
  logic                in_prep;
  logic                in_run;
  logic                wrote;
  logic [TimeoutW:0]   wait_inc;
  logic [7:0]          addr_wr;
  logic [7:0]          addr_rd;

  assign len_ext = CmpW'(item_i.length);
  assign len_sat = (len_ext > MaxLen) ? MaxLen : len_ext;
  assign bl_dec  = (bytes_left_i != '0) ? bytes_left_i - LenW'(1) : bytes_left_i;
  assign addr_wr = {state_i.held_device, 1'b0};
  assign addr_rd = {state_i.held_device, 1'b1};
  assign wait_inc = {1'b0, state_i.wait_count} + (TimeoutW+1)'(1);

  assign in_prep = (state_i.phase == PH_PREP_CLEAR) || (state_i.phase == PH_PREP_READY) ||
                   (state_i.phase == PH_PREP_NOTBUSY) || (state_i.phase == PH_START_PRE);
  assign in_run  = (state_i.phase == PH_RUN_START) || (state_i.phase == PH_RUN_ADDR) ||
                   (state_i.phase == PH_RUN_REG) || (state_i.phase == PH_RUN_RESTART) ||
                   (state_i.phase == PH_RUN_ADDR2) || (state_i.phase == PH_RUN_WDATA) ||
                   (state_i.phase == PH_RUN_RDATA) || (state_i.phase == PH_RUN_STOP) ||
                   (state_i.phase == PH_RUN_FAILSTOP);
  assign wrote   = (state_i.phase == PH_RUN_ADDR) || (state_i.phase == PH_RUN_REG) ||
                   (state_i.phase == PH_RUN_ADDR2) || (state_i.phase == PH_RUN_WDATA);

  always_comb begin
    st       = state_i;
    bl       = bytes_left_i;
    r        = '0;
    do_iss   = 1'b0;
    iss_cmd  = CMD_NONE;
    iss_data = '0;
    iss_ph   = PH_IDLE;
    do_fin   = 1'b0;
    fin_st   = ST_OK;
    do_ask   = 1'b0;
    adv_en   = 1'b0;
    adv_from = PH_PREP_READY;

    unique case (item_i.op)
      OP_REQUEST: begin
        if (state_i.phase == PH_IDLE && item_i.kind <= KIND_REG_READ) begin
          st.held_kind       = item_i.kind;
          st.held_device     = item_i.dev_addr;
          st.held_register   = item_i.reg_addr;
          bl                 = (item_i.kind == KIND_PROBE) ? '0 : LenW'(len_sat);
          st.saw_not_ready   = 1'b0;
          st.wait_count      = '0;
          st.pending_failure = ST_OK;
          if (item_i.kind != KIND_PROBE && item_i.kind != KIND_REG_WRITE &&
              item_i.length == 8'd0) begin
            do_fin = 1'b1;
            fin_st = ST_OK;
          end else begin
            st.phase = PH_PREP_CHECK;
          end
        end
      end
      OP_WBYTE: begin
        if (state_i.phase == PH_AWAIT_BYTE) begin
          do_iss   = 1'b1;
          iss_cmd  = CMD_WRITE;
          iss_data = item_i.write_byte;
          iss_ph   = PH_RUN_WDATA;
        end
      end
      OP_STATUS: begin
        if (state_i.phase == PH_PREP_CHECK) begin
          if (item_i.core_arb_lost) begin
            r.clear_arb_lost = 1'b1;
            st.phase         = PH_PREP_CLEAR;
          end else begin
            adv_en = 1'b1;
          end
        end else if (state_i.phase == PH_PREP_CLEAR) begin
          adv_en = !item_i.core_arb_lost;
        end else if (in_prep) begin
          adv_en   = 1'b1;
          adv_from = state_i.phase;
        end else if (state_i.phase == PH_FAIL_CHECK) begin
          if (!item_i.core_arb_lost && item_i.core_ready) begin
            do_iss = 1'b1;
            iss_cmd = CMD_STOP;
            iss_ph = PH_RUN_FAILSTOP;
          end else begin
            do_fin = 1'b1;
            fin_st = state_i.pending_failure;
          end
        end else if (in_run) begin
          if (item_i.core_arb_lost) begin
            do_fin = 1'b1;
            fin_st = (state_i.phase == PH_RUN_FAILSTOP) ? state_i.pending_failure : ST_ARB;
          end else if (!state_i.saw_not_ready) begin
            if (!item_i.core_ready) begin
              st.saw_not_ready = 1'b1;
              st.wait_count    = '0;
            end
          end else if (item_i.core_ready) begin
            if (wrote && item_i.core_nack) begin
              st.pending_failure = ST_NACK;
              do_iss  = 1'b1;
              iss_cmd = CMD_STOP;
              iss_ph  = PH_RUN_FAILSTOP;
            end else begin
              unique case (state_i.phase)
                PH_RUN_START: begin
                  do_iss   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_data = (state_i.held_kind == KIND_READ) ? addr_rd : addr_wr;
                  iss_ph   = PH_RUN_ADDR;
                end
                PH_RUN_ADDR: begin
                  if (state_i.held_kind == KIND_PROBE) begin
                    do_iss  = 1'b1;
                    iss_cmd = CMD_STOP;
                    iss_ph  = PH_RUN_STOP;
                  end else if (state_i.held_kind == KIND_WRITE) begin
                    do_ask = 1'b1;
                  end else if (state_i.held_kind == KIND_READ) begin
                    do_iss   = 1'b1;
                    iss_cmd  = CMD_READ;
                    iss_data = {7'd0, bytes_left_i == LenW'(1)};
                    iss_ph   = PH_RUN_RDATA;
                  end else begin
                    do_iss   = 1'b1;
                    iss_cmd  = CMD_WRITE;
                    iss_data = state_i.held_register;
                    iss_ph   = PH_RUN_REG;
                  end
                end
                PH_RUN_REG: begin
                  if (state_i.held_kind == KIND_REG_READ) begin
                    do_iss  = 1'b1;
                    iss_cmd = CMD_RESTART;
                    iss_ph  = PH_RUN_RESTART;
                  end else if (bytes_left_i == '0) begin
                    do_iss  = 1'b1;
                    iss_cmd = CMD_STOP;
                    iss_ph  = PH_RUN_STOP;
                  end else begin
                    do_ask = 1'b1;
                  end
                end
                PH_RUN_RESTART: begin
                  do_iss   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_data = addr_rd;
                  iss_ph   = PH_RUN_ADDR2;
                end
                PH_RUN_ADDR2: begin
                  do_iss   = 1'b1;
                  iss_cmd  = CMD_READ;
                  iss_data = {7'd0, bytes_left_i == LenW'(1)};
                  iss_ph   = PH_RUN_RDATA;
                end
                PH_RUN_WDATA: begin
                  bl = bl_dec;
                  if (bl_dec == '0) begin
                    do_iss  = 1'b1;
                    iss_cmd = CMD_STOP;
                    iss_ph  = PH_RUN_STOP;
                  end else begin
                    do_ask = 1'b1;
                  end
                end
                PH_RUN_RDATA: begin
                  r.read_valid = 1'b1;
                  r.read_byte  = item_i.core_rdata;
                  bl           = bl_dec;
                  do_iss       = 1'b1;
                  if (bl_dec == '0) begin
                    iss_cmd = CMD_STOP;
                    iss_ph  = PH_RUN_STOP;
                  end else begin
                    iss_cmd  = CMD_READ;
                    iss_data = {7'd0, bl_dec == LenW'(1)};
                    iss_ph   = PH_RUN_RDATA;
                  end
                end
                PH_RUN_STOP: begin
                  do_fin = 1'b1;
                  fin_st = ST_OK;
                end
                default: begin
                  do_fin = 1'b1;
                  fin_st = state_i.pending_failure;
                end
              endcase
            end
          end
        end
      end
      OP_TICK: begin
        if (in_prep || in_run) begin
          if (wait_inc >= {1'b0, timeout_i}) begin
            if (in_prep || state_i.phase == PH_RUN_START || state_i.phase == PH_RUN_STOP) begin
              do_fin = 1'b1;
              fin_st = ST_TIMEOUT;
            end else if (state_i.phase == PH_RUN_FAILSTOP) begin
              do_fin = 1'b1;
              fin_st = state_i.pending_failure;
            end else begin
              st.pending_failure = ST_TIMEOUT;
              st.phase           = PH_FAIL_CHECK;
              st.saw_not_ready   = 1'b0;
            end
          end else begin
            st.wait_count = wait_inc[TimeoutW-1:0];
          end
        end
      end
      default: ;
    endcase

    // bus preparation: ready, then not busy, then ready again
    if (adv_en) begin
      if (item_i.core_arb_lost) begin
        do_fin = 1'b1;
        fin_st = ST_ARB;
      end else if (adv_from == PH_PREP_READY && !item_i.core_ready) begin
        st.phase = PH_PREP_READY;
      end else if (adv_from != PH_START_PRE && item_i.core_busy) begin
        st.phase = PH_PREP_NOTBUSY;
      end else if (!item_i.core_ready) begin
        st.phase = PH_START_PRE;
      end else begin
        do_iss  = 1'b1;
        iss_cmd = CMD_START;
        iss_ph  = PH_RUN_START;
      end
    end

    if (st.phase != state_i.phase) begin
      st.wait_count = '0;
    end

    if (do_iss) begin
      r.cmd            = iss_cmd;
      r.cmd_data       = iss_data;
      st.phase         = iss_ph;
      st.saw_not_ready = 1'b0;
      st.wait_count    = '0;
    end
    if (do_ask) begin
      r.want_write_byte = 1'b1;
      st.phase          = PH_AWAIT_BYTE;
      st.saw_not_ready  = 1'b0;
      st.wait_count     = '0;
    end
    if (do_fin) begin
      r.done_res         = 1'b1;
      r.status           = fin_st;
      st.phase           = PH_IDLE;
      st.saw_not_ready   = 1'b0;
      st.wait_count      = '0;
      st.pending_failure = ST_OK;
    end
  end

  assign state_o      = st;
  assign bytes_left_o = bl;
  assign res_o        = r;
  assign res_valid_o  = (r.cmd != CMD_NONE) || r.clear_arb_lost || r.want_write_byte ||
                        r.read_valid || r.done_res;

endmodule

// File: hdl/i2c_transaction_sequencer_top.sv
// A result passes from the input register through the step logic into the output register.
// Throughput: one item per cycle unless the result stream stalls; the input register
// and the result register each take a new entry whenever the stage behind them moves.
// Reset: sequencer idle, all held request state zero, timeout_ticks 1000000.
// ----------------------------------------------------------------------------
// I2C transaction sequencer top level
// Stream front end, state registers and result register around the step logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_transaction_sequencer_top import i2cts_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,   // timeout_ticks
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // kind, dev_addr, reg_addr, length, write_byte, core_ready, core_busy,
  // core_arb_lost, core_nack, core_rdata, zero fill
  input  logic [47:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,  // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // cmd, cmd_data, clear_arb_lost, want_write_byte, read_valid, read_byte,
  // done_res, status, zero fill
  output logic [31:0]         m_axis_tdata
);

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);

  logic [TimeoutW-1:0] timeout_q;
  logic                in_valid_q;
  item_t               in_item_q;
  seq_state_t          state_q, state_d;
  logic [LenW-1:0]     bytes_left_q, bytes_left_d;
  logic                out_valid_q;
  result_t             out_res_q;
  result_t             res;
  logic                res_valid;
  logic                out_free;
  logic                fire;
  item_t               s_item;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;

  assign s_item.op            = op_e'(s_axis_tuser);
  assign s_item.kind          = s_axis_tdata[2:0];
  assign s_item.dev_addr      = s_axis_tdata[9:3];
  assign s_item.reg_addr      = s_axis_tdata[17:10];
  assign s_item.length        = s_axis_tdata[25:18];
  assign s_item.write_byte    = s_axis_tdata[33:26];
  assign s_item.core_ready    = s_axis_tdata[34];
  assign s_item.core_busy     = s_axis_tdata[35];
  assign s_item.core_arb_lost = s_axis_tdata[36];
  assign s_item.core_nack     = s_axis_tdata[37];
  assign s_item.core_rdata    = s_axis_tdata[45:38];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutResetVal;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_item;
    end
  end

  i2cts_step #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_step (
    .item_i       (in_item_q),
    .state_i      (state_q),
    .bytes_left_i (bytes_left_q),
    .timeout_i    (timeout_q),
    .state_o      (state_d),
    .bytes_left_o (bytes_left_d),
    .res_o        (res),
    .res_valid_o  (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PH_IDLE;
      state_q.held_kind       <= '0;
      state_q.held_device     <= '0;
      state_q.held_register   <= '0;
      state_q.saw_not_ready   <= 1'b0;
      state_q.wait_count      <= '0;
      state_q.pending_failure <= '0;
      bytes_left_q            <= '0;
    end else if (fire) begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.status, out_res_q.done_res, out_res_q.read_byte,
                          out_res_q.read_valid, out_res_q.want_write_byte,
                          out_res_q.clear_arb_lost, out_res_q.cmd_data, out_res_q.cmd};

endmodule

// File: hdl/i2cts_checker.sv
// ----------------------------------------------------------------------------
// I2C transaction sequencer checker
// Port-level properties of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_transaction_sequencer_top_defines.svh"

module i2cts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `I2CTS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `I2CTS_ASSERT_IMP(a_status_done, m_axis_tvalid && !m_axis_tdata[22], m_axis_tdata[24:23] == 2'd0, "status set without done")
  `I2CTS_ASSERT_IMP(a_cmd_data, m_axis_tvalid && m_axis_tdata[2:0] == 3'd0, m_axis_tdata[10:3] == 8'd0, "command data without command")
  `I2CTS_ASSERT_IMP(a_cmd_done, m_axis_tvalid && m_axis_tdata[2:0] != 3'd0, !m_axis_tdata[22], "command issued together with done")

endmodule

bind i2c_transaction_sequencer_top i2cts_checker u_i2cts_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// I2C transaction sequencer testbench
// Streams requests, write bytes, core status reports and ticks into the
// sequencer. A built-in model of the sequencer predicts every command, pulse
// and completion, and each output transfer is checked against it. The run
// steps through several timeout settings with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import i2cts_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [2:0] KIND_BAD = 3'd7;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  i2c_transaction_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // sequencer model state
  phase_e      sq_phase = PH_IDLE;
  logic [2:0]  sq_kind = '0;
  logic [6:0]  sq_dev = '0;
  logic [7:0]  sq_reg = '0;
  logic [7:0]  sq_left = '0;
  logic        sq_saw_low = 1'b0;
  logic [19:0] sq_wait = '0;
  logic [1:0]  sq_pend = '0;
  logic [19:0] tmo_ticks = TimeoutResetVal;
  result_t     step_out;
  bit          step_has_out;

  item_t   core_traffic[$];
  result_t sequencer_outputs_due[$];
  item_t   cur_item;
  int      queued = 0;
  int      transfers_in = 0;
  int      outputs_checked = 0;
  int      mismatch_cnt = 0;
  int      close_tally[4] = '{0, 0, 0, 0};
  int      cycle_count = 0;
  bit      steady = 1'b0;
  bit      clean = 1'b0;

  function automatic void issue_cmd(cmd_e c, logic [7:0] d, phase_e nxt);
    step_out.cmd = c;
    step_out.cmd_data = d;
    step_has_out = 1'b1;
    sq_phase = nxt;
    sq_saw_low = 1'b0;
    sq_wait = '0;
  endfunction

  function automatic void issue_read();
    issue_cmd(CMD_READ, (sq_left == 8'd1) ? 8'd1 : 8'd0, PH_RUN_RDATA);
  endfunction

  function automatic void finish_txn(logic [1:0] st);
    step_out.done_res = 1'b1;
    step_out.status = st;
    step_has_out = 1'b1;
    sq_phase = PH_IDLE;
    sq_saw_low = 1'b0;
    sq_wait = '0;
    sq_pend = '0;
  endfunction

  function automatic void ask_byte();
    step_out.want_write_byte = 1'b1;
    step_has_out = 1'b1;
    sq_phase = PH_AWAIT_BYTE;
    sq_saw_low = 1'b0;
    sq_wait = '0;
  endfunction

  function automatic void fail_cmd(logic [1:0] st, bit have_report, logic ready, logic arb);
    if (sq_phase == PH_RUN_START || sq_phase == PH_RUN_STOP) begin
      finish_txn(st);
    end else if (sq_phase == PH_RUN_FAILSTOP) begin
      finish_txn(sq_pend);
    end else begin
      sq_pend = st;
      if (!have_report) begin
        sq_phase = PH_FAIL_CHECK;
        sq_saw_low = 1'b0;
        sq_wait = '0;
      end else if (!arb && ready) begin
        issue_cmd(CMD_STOP, 8'h00, PH_RUN_FAILSTOP);
      end else begin
        finish_txn(st);
      end
    end
  endfunction

  // ready, then bus free, then ready again before the start goes out
  function automatic void advance_prep(logic ready, logic busy, logic arb);
    bit going;
    going = 1'b1;
    while (going) begin
      going = 1'b0;
      if (arb) begin
        finish_txn(ST_ARB);
      end else if (sq_phase == PH_PREP_READY) begin
        if (ready) begin
          sq_phase = PH_PREP_NOTBUSY;
          sq_wait = '0;
          going = 1'b1;
        end
      end else if (sq_phase == PH_PREP_NOTBUSY) begin
        if (!busy) begin
          sq_phase = PH_START_PRE;
          sq_wait = '0;
          going = 1'b1;
        end
      end else if (ready) begin
        issue_cmd(CMD_START, 8'h00, PH_RUN_START);
      end
    end
  endfunction

  function automatic void sequence_step(item_t it);
    logic [7:0] len;
    bit wrote;
    bit prep;
    bit run;
    step_out = '0;
    step_has_out = 1'b0;
    prep = sq_phase >= PH_PREP_CLEAR && sq_phase <= PH_START_PRE;
    run = sq_phase >= PH_RUN_START && sq_phase <= PH_RUN_FAILSTOP;
    case (it.op)
      OP_REQUEST: begin
        if (sq_phase == PH_IDLE && it.kind <= KIND_REG_READ) begin
          len = (it.length > MaxLengthDef) ? 8'(MaxLengthDef) : it.length;
          sq_kind = it.kind;
          sq_dev = it.dev_addr;
          sq_reg = it.reg_addr;
          sq_left = (it.kind == KIND_PROBE) ? 8'd0 : len;
          sq_saw_low = 1'b0;
          sq_wait = '0;
          sq_pend = '0;
          if (it.kind != KIND_PROBE && it.kind != KIND_REG_WRITE && len == 8'd0) begin
            finish_txn(ST_OK);
          end else begin
            sq_phase = PH_PREP_CHECK;
          end
        end
      end
      OP_WBYTE: begin
        if (sq_phase == PH_AWAIT_BYTE) issue_cmd(CMD_WRITE, it.write_byte, PH_RUN_WDATA);
      end
      OP_STATUS: begin
        if (sq_phase == PH_PREP_CHECK) begin
          if (it.core_arb_lost) begin
            step_out.clear_arb_lost = 1'b1;
            step_has_out = 1'b1;
            sq_phase = PH_PREP_CLEAR;
            sq_wait = '0;
          end else begin
            sq_phase = PH_PREP_READY;
            sq_wait = '0;
            advance_prep(it.core_ready, it.core_busy, it.core_arb_lost);
          end
        end else if (sq_phase == PH_PREP_CLEAR) begin
          if (!it.core_arb_lost) begin
            sq_phase = PH_PREP_READY;
            sq_wait = '0;
            advance_prep(it.core_ready, it.core_busy, it.core_arb_lost);
          end
        end else if (sq_phase >= PH_PREP_READY && sq_phase <= PH_START_PRE) begin
          advance_prep(it.core_ready, it.core_busy, it.core_arb_lost);
        end else if (sq_phase == PH_FAIL_CHECK) begin
          if (!it.core_arb_lost && it.core_ready) issue_cmd(CMD_STOP, 8'h00, PH_RUN_FAILSTOP);
          else finish_txn(sq_pend);
        end else if (run) begin
          if (it.core_arb_lost) begin
            fail_cmd(ST_ARB, 1'b1, it.core_ready, it.core_arb_lost);
          end else if (!sq_saw_low) begin
            if (!it.core_ready) begin
              sq_saw_low = 1'b1;
              sq_wait = '0;
            end
          end else if (it.core_ready) begin
            wrote = sq_phase == PH_RUN_ADDR || sq_phase == PH_RUN_REG ||
                    sq_phase == PH_RUN_ADDR2 || sq_phase == PH_RUN_WDATA;
            if (wrote && it.core_nack) begin
              fail_cmd(ST_NACK, 1'b1, 1'b1, 1'b0);
            end else begin
              case (sq_phase)
                PH_RUN_START: issue_cmd(CMD_WRITE, {sq_dev, sq_kind == KIND_READ}, PH_RUN_ADDR);
                PH_RUN_ADDR: begin
                  if (sq_kind == KIND_PROBE) issue_cmd(CMD_STOP, 8'h00, PH_RUN_STOP);
                  else if (sq_kind == KIND_WRITE) ask_byte();
                  else if (sq_kind == KIND_READ) issue_read();
                  else issue_cmd(CMD_WRITE, sq_reg, PH_RUN_REG);
                end
                PH_RUN_REG: begin
                  if (sq_kind == KIND_REG_READ) issue_cmd(CMD_RESTART, 8'h00, PH_RUN_RESTART);
                  else if (sq_left == 8'd0) issue_cmd(CMD_STOP, 8'h00, PH_RUN_STOP);
                  else ask_byte();
                end
                PH_RUN_RESTART: issue_cmd(CMD_WRITE, {sq_dev, 1'b1}, PH_RUN_ADDR2);
                PH_RUN_ADDR2: issue_read();
                PH_RUN_WDATA: begin
                  if (sq_left != 8'd0) sq_left = sq_left - 8'd1;
                  if (sq_left == 8'd0) issue_cmd(CMD_STOP, 8'h00, PH_RUN_STOP);
                  else ask_byte();
                end
                PH_RUN_RDATA: begin
                  step_out.read_valid = 1'b1;
                  step_out.read_byte = it.core_rdata;
                  step_has_out = 1'b1;
                  if (sq_left != 8'd0) sq_left = sq_left - 8'd1;
                  if (sq_left == 8'd0) issue_cmd(CMD_STOP, 8'h00, PH_RUN_STOP);
                  else issue_read();
                end
                PH_RUN_STOP: finish_txn(ST_OK);
                default: finish_txn(sq_pend);
              endcase
            end
          end
        end
      end
      default: begin
        if (prep || run) begin
          if (({1'b0, sq_wait} + 21'd1) >= {1'b0, tmo_ticks}) begin
            if (prep) finish_txn(ST_TIMEOUT);
            else fail_cmd(ST_TIMEOUT, 1'b0, 1'b0, 1'b0);
          end else begin
            sq_wait = sq_wait + 20'd1;
          end
        end
      end
    endcase
  endfunction

  function automatic string show(result_t r);
    return $sformatf("cmd=%0d data=%02h clr=%0b want=%0b rv=%0b rbyte=%02h done=%0b st=%0d",
                     r.cmd, r.cmd_data, r.clear_arb_lost, r.want_write_byte, r.read_valid,
                     r.read_byte, r.done_res, r.status);
  endfunction

  // traffic generation
  function automatic item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return item_t'(raw[47:0]);
  endfunction

  function automatic bit coin();
    return ($urandom & 1) != 0;
  endfunction

  function automatic bit rare(int pct);
    return !clean && $urandom_range(0, 99) < pct;
  endfunction

  function automatic void queue_item(item_t it);
    core_traffic.push_back(it);
    queued++;
  endfunction

  function automatic void push_plain(op_e op);
    item_t it;
    it = noise_item();
    it.op = op;
    queue_item(it);
  endfunction

  function automatic void push_req(logic [2:0] kind, logic [6:0] dev, logic [7:0] regi,
                                   logic [7:0] len);
    item_t it;
    it = noise_item();
    it.op = OP_REQUEST;
    it.kind = kind;
    it.dev_addr = dev;
    it.reg_addr = regi;
    it.length = len;
    queue_item(it);
  endfunction

  function automatic void push_report(logic ready, logic busy, logic arb, logic nack);
    item_t it;
    it = noise_item();
    it.op = OP_STATUS;
    it.core_ready = ready;
    it.core_busy = busy;
    it.core_arb_lost = arb;
    it.core_nack = nack;
    queue_item(it);
  endfunction

  function automatic void maybe_ticks();
    if (rare(15)) repeat ($urandom_range(1, 5)) push_plain(OP_TICK);
  endfunction

  // one command as the core sees it: accepted, completed, then a data byte offer
  function automatic void cmd_cycle();
    maybe_ticks();
    push_report(1'b0, coin(), rare(2), coin());
    maybe_ticks();
    push_report(1'b1, coin(), rare(2), rare(5));
    push_plain(OP_WBYTE);
    if (rare(4)) queue_item(noise_item());
  endfunction

  function automatic void transaction(logic [2:0] kind, logic [7:0] len);
    int steps;
    push_req(kind, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len);
    case (kind)
      KIND_PROBE: steps = 3;
      KIND_WRITE, KIND_READ: steps = (len == 8'd0) ? 0 : len + 3;
      KIND_REG_WRITE: steps = len + 4;
      default: steps = (len == 8'd0) ? 0 : len + 6;
    endcase
    if (steps > 0) begin
      if (rare(15)) push_report(coin(), coin(), 1'b1, coin());
      if (rare(25)) push_report(1'b0, coin(), 1'b0, coin());
      if (rare(25)) push_report(1'b1, 1'b1, 1'b0, coin());
      maybe_ticks();
      push_report(1'b1, 1'b0, 1'b0, coin());
      repeat (steps) cmd_cycle();
    end
  endfunction

  function automatic void random_phase(int n);
    int stop_at;
    int pick;
    logic [7:0] len;
    stop_at = queued + n;
    while (queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 8'd0;
      else if (pick < 85) len = 8'($urandom_range(1, 4));
      else len = 8'($urandom_range(5, 12));
      if (rare(3)) push_req(3'($urandom_range(KIND_REG_READ + 1, KIND_BAD)),
                            7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      transaction(3'($urandom_range(KIND_PROBE, KIND_REG_READ)), len);
    end
  endfunction

  task automatic drain();
    while (core_traffic.size() != 0 || s_axis_tvalid || sequencer_outputs_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [19:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tmo_ticks = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sequence_step(cur_item);
        transfers_in++;
        if (step_has_out) sequencer_outputs_due.push_back(step_out);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (core_traffic.size() != 0 && (steady || $urandom_range(0, 99) >= 31)) begin
          cur_item = core_traffic.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_item.op;
          s_axis_tdata <= {2'b00, cur_item.core_rdata, cur_item.core_nack,
                           cur_item.core_arb_lost, cur_item.core_busy, cur_item.core_ready,
                           cur_item.write_byte, cur_item.length, cur_item.reg_addr,
                           cur_item.dev_addr, cur_item.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t due;
    string bad;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cmd = cmd_e'(m_axis_tdata[2:0]);
        got.cmd_data = m_axis_tdata[10:3];
        got.clear_arb_lost = m_axis_tdata[11];
        got.want_write_byte = m_axis_tdata[12];
        got.read_valid = m_axis_tdata[13];
        got.read_byte = m_axis_tdata[21:14];
        got.done_res = m_axis_tdata[22];
        got.status = m_axis_tdata[24:23];
        if (sequencer_outputs_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected output transfer: %s", show(got));
        end else begin
          due = sequencer_outputs_due.pop_front();
          outputs_checked++;
          if (due.done_res) close_tally[due.status]++;
          bad = "";
          if (got.cmd != due.cmd) bad = {bad, " cmd"};
          if (got.cmd_data != due.cmd_data) bad = {bad, " cmd_data"};
          if (got.clear_arb_lost != due.clear_arb_lost) bad = {bad, " clear_arb_lost"};
          if (got.want_write_byte != due.want_write_byte) bad = {bad, " want_write_byte"};
          if (got.read_valid != due.read_valid) bad = {bad, " read_valid"};
          if (got.read_byte != due.read_byte) bad = {bad, " read_byte"};
          if (got.done_res != due.done_res) bad = {bad, " done_res"};
          if (got.status != due.status) bad = {bad, " status"};
          if (bad != "") begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("output %0d differs in%s: expected %s, got %s",
                       outputs_checked, bad, show(due), show(got));
          end
        end
      end
      m_axis_tready <= steady || $urandom_range(0, 99) >= 31;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d outputs still due", cycle_count,
               sequencer_outputs_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray traffic while idle
    push_plain(OP_TICK);
    push_plain(OP_STATUS);
    push_plain(OP_WBYTE);
    // probe of the top address, nacked, length ignored
    push_req(KIND_PROBE, 7'h7F, 8'hFF, 8'hFF);
    push_report(1'b1, 1'b0, 1'b0, 1'b0);
    push_report(1'b0, 1'b1, 1'b0, 1'b0);
    push_report(1'b1, 1'b1, 1'b0, 1'b0);
    push_report(1'b0, 1'b1, 1'b0, 1'b0);
    push_report(1'b1, 1'b1, 1'b0, 1'b1);
    push_report(1'b0, 1'b1, 1'b0, 1'b0);
    push_report(1'b1, 1'b0, 1'b0, 1'b0);
    // zero length read, unknown kind
    push_req(KIND_READ, 7'h00, 8'h00, 8'h00);
    push_req(KIND_BAD, 7'h2A, 8'h55, 8'h01);
    // zero length register write with arbitration clear and prep waits
    push_req(KIND_REG_WRITE, 7'h00, 8'h00, 8'h00);
    push_report(1'b0, 1'b0, 1'b1, 1'b0);
    push_req(KIND_READ, 7'h55, 8'hAA, 8'h03);
    push_report(1'b0, 1'b1, 1'b0, 1'b0);
    push_report(1'b1, 1'b1, 1'b0, 1'b0);
    push_report(1'b0, 1'b0, 1'b0, 1'b0);
    push_report(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (4) begin
      push_report(1'b0, 1'b1, 1'b0, 1'b0);
      push_report(1'b1, 1'b1, 1'b0, 1'b0);
    end

    random_phase(180);
    write_timeout(20'd1);
    random_phase(70);
    write_timeout(20'hFFFFF);
    clean = 1'b1;
    transaction(KIND_READ, 8'd255);
    clean = 1'b0;
    random_phase(130);
    write_timeout(20'd4);
    steady = 1'b1;
    random_phase(140);
    write_timeout(20'd0);
    steady = 1'b0;
    random_phase(50);
    write_timeout(20'd2);
    random_phase(50);
    drain();

    $display("covered %0d inputs, %0d outputs; closes %0d ok %0d nack %0d arb %0d timeout",
             transfers_in, outputs_checked, close_tally[ST_OK], close_tally[ST_NACK],
             close_tally[ST_ARB], close_tally[ST_TIMEOUT]);
    $display("timeout settings: reset value, 1, max, 4, 0, 2; one full 255 byte read");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
